FILE: design/tlbe_pkg.sv
`timescale 1ns / 1ps
package tlbe_pkg;

    localparam int DEF_LINES = 64;
    localparam int DEF_COLS  = 128;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 4;
    localparam int ROW_IO_W  = 6;
    localparam int COL_IO_W  = 7;
    localparam int TOTAL_O_W = 7;

    // Command kinds
    localparam logic [KIND_W-1:0] K_INSERT     = 4'd0;
    localparam logic [KIND_W-1:0] K_DELETE     = 4'd1;
    localparam logic [KIND_W-1:0] K_DEL_WORD   = 4'd2;
    localparam logic [KIND_W-1:0] K_LEFT       = 4'd3;
    localparam logic [KIND_W-1:0] K_RIGHT      = 4'd4;
    localparam logic [KIND_W-1:0] K_UP         = 4'd5;
    localparam logic [KIND_W-1:0] K_DOWN       = 4'd6;
    localparam logic [KIND_W-1:0] K_WORD_LEFT  = 4'd7;
    localparam logic [KIND_W-1:0] K_WORD_RIGHT = 4'd8;
    localparam logic [KIND_W-1:0] K_READ       = 4'd9;
    localparam logic [KIND_W-1:0] K_CLEAR      = 4'd10;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   char_code;
        logic [ROW_IO_W-1:0] read_row;
        logic [COL_IO_W-1:0] read_col;
    } in_word_t;

    typedef struct packed {
        logic                 status;
        logic [ROW_IO_W-1:0]  cur_row;
        logic [COL_IO_W-1:0]  cur_col;
        logic [TOTAL_O_W-1:0] rows_used;
        logic [BYTE_W-1:0]    read_byte;
    } out_word_t;

    // Block move mode
    typedef struct packed {
        logic desc;
        logic fill;
    } mv_op_t;

endpackage

FILE: design/tlbe_mem.sv
`timescale 1ns / 1ps
module tlbe_mem #(
    parameter int AW = 13
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [tlbe_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [tlbe_pkg::BYTE_W-1:0] rdata
);
    import tlbe_pkg::*;

    logic [BYTE_W-1:0] mem [2**AW];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tlbe_mover.sv
`timescale 1ns / 1ps
module tlbe_mover #(
    parameter int AW = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [AW-1:0]               src,
    input  logic [AW-1:0]               dst,
    input  logic [AW:0]                 cnt,
    input  tlbe_pkg::mv_op_t            op,
    output logic                        busy,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [tlbe_pkg::BYTE_W-1:0] mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [tlbe_pkg::BYTE_W-1:0] mem_rdata
);
    import tlbe_pkg::*;

    logic          busy_reg, busy_next;
    logic          pend_reg, pend_next;
    logic [AW:0]   rem_reg, rem_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    mv_op_t        op_reg, op_next;
    logic          have_rem;

    assign have_rem  = (rem_reg != '0);
    assign busy      = busy_reg;
    assign mem_re    = busy_reg && !op_reg.fill && have_rem;
    assign mem_raddr = src_reg;
    assign mem_we    = busy_reg && (op_reg.fill ? have_rem : pend_reg);
    assign mem_waddr = dst_reg;
    assign mem_wdata = op_reg.fill ? BYTE_W'(0) : mem_rdata;

    always_comb begin
        busy_next = busy_reg;
        pend_next = pend_reg;
        rem_next  = rem_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        op_next   = op_reg;
        if (start) begin
            busy_next = (cnt != '0);
            pend_next = 1'b0;
            rem_next  = cnt;
            src_next  = src;
            dst_next  = dst;
            op_next   = op;
        end else if (busy_reg) begin
            if (op_reg.fill) begin
                // one zero byte a cycle
                rem_next = rem_reg - (AW+1)'(1);
                dst_next = op_reg.desc ? dst_reg - AW'(1) : dst_reg + AW'(1);
            end else begin
                // read ahead one byte, write the byte read last cycle
                pend_next = have_rem;
                if (have_rem) begin
                    rem_next = rem_reg - (AW+1)'(1);
                    src_next = op_reg.desc ? src_reg - AW'(1) : src_reg + AW'(1);
                end
                if (pend_reg) begin
                    dst_next = op_reg.desc ? dst_reg - AW'(1) : dst_reg + AW'(1);
                end
            end
            busy_next = (rem_next != '0) || pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            rem_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            rem_reg  <= rem_next;
        end
        src_reg <= src_next;
        dst_reg <= dst_next;
        op_reg  <= op_next;
    end

endmodule

FILE: design/tlbe_ctrl.sv
`timescale 1ns / 1ps
module tlbe_ctrl #(
    parameter int LINES = tlbe_pkg::DEF_LINES,
    parameter int COLS  = tlbe_pkg::DEF_COLS,
    parameter int RW    = $clog2(LINES),
    parameter int CW    = $clog2(COLS),
    parameter int AW    = RW + CW
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tlbe_pkg::in_word_t          in_word,
    input  logic                        res_ready,
    output logic                        res_valid,
    output tlbe_pkg::out_word_t         res_word,
    output logic                        mv_start,
    output logic [AW-1:0]               mv_src,
    output logic [AW-1:0]               mv_dst,
    output logic [AW:0]                 mv_cnt,
    output tlbe_pkg::mv_op_t            mv_op,
    input  logic                        mv_busy,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [tlbe_pkg::BYTE_W-1:0] mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [tlbe_pkg::BYTE_W-1:0] mem_rdata
);
    import tlbe_pkg::*;

    localparam int SW = 5;
    localparam logic [SW-1:0] ST_IDLE   = 5'd0;
    localparam logic [SW-1:0] ST_DISP   = 5'd1;
    localparam logic [SW-1:0] ST_FIN    = 5'd2;
    localparam logic [SW-1:0] ST_CLR    = 5'd3;
    localparam logic [SW-1:0] ST_MWAIT  = 5'd4;
    localparam logic [SW-1:0] ST_LEN_RD = 5'd5;
    localparam logic [SW-1:0] ST_LEN_EV = 5'd6;
    localparam logic [SW-1:0] ST_WL_RD  = 5'd7;
    localparam logic [SW-1:0] ST_WL_EV  = 5'd8;
    localparam logic [SW-1:0] ST_WR_RD  = 5'd9;
    localparam logic [SW-1:0] ST_WR_EV  = 5'd10;
    localparam logic [SW-1:0] ST_RT_EV  = 5'd11;
    localparam logic [SW-1:0] ST_RD_EV  = 5'd12;
    localparam logic [SW-1:0] ST_INS1   = 5'd13;
    localparam logic [SW-1:0] ST_INS2   = 5'd14;
    localparam logic [SW-1:0] ST_SPL1   = 5'd15;
    localparam logic [SW-1:0] ST_SPL2   = 5'd16;
    localparam logic [SW-1:0] ST_SPL3   = 5'd17;
    localparam logic [SW-1:0] ST_SPL4   = 5'd18;
    localparam logic [SW-1:0] ST_DEL_A  = 5'd19;
    localparam logic [SW-1:0] ST_DEL1   = 5'd20;
    localparam logic [SW-1:0] ST_DEL2   = 5'd21;
    localparam logic [SW-1:0] ST_DEL3   = 5'd22;
    localparam logic [SW-1:0] ST_DEL4   = 5'd23;
    localparam logic [SW-1:0] ST_DEL5   = 5'd24;
    localparam logic [SW-1:0] ST_DW1    = 5'd25;
    localparam logic [SW-1:0] ST_DW2    = 5'd26;
    localparam logic [SW-1:0] ST_LFT1   = 5'd27;
    localparam logic [SW-1:0] ST_CLAMP  = 5'd28;

    localparam int CNT_W = AW + 1;
    localparam logic [CNT_W-1:0] ROW_SPAN = CNT_W'(1) << CW;
    localparam logic [CW-1:0]    COL_LAST = CW'(COLS - 1);
    localparam logic [CW-1:0]    COL_TOP  = '1;

    logic [SW-1:0]     state_reg, state_next;
    logic [SW-1:0]     ret_reg, ret_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW:0]       total_reg, total_next;
    logic [RW-1:0]     scan_row_reg, scan_row_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [CW-1:0]     aux_reg, aux_next;
    logic              phase_reg, phase_next;
    in_word_t          cmd_reg, cmd_next;
    logic              status_reg, status_next;
    logic [BYTE_W-1:0] rbyte_reg, rbyte_next;

    logic [RW:0]       rows_below;
    logic [RW-1:0]     row_up;
    logic [RW-1:0]     row_dn;
    logic [RW-1:0]     last_row;
    logic              is_space;

    assign rows_below = total_reg - (RW+1)'(1) - (RW+1)'(row_reg);
    assign row_up     = row_reg - RW'(1);
    assign row_dn     = row_reg + RW'(1);
    assign last_row   = RW'(total_reg - (RW+1)'(1));
    assign is_space   = (mem_rdata == CH_SPACE);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN) && res_ready;

    always_comb begin
        res_word           = '0;
        res_word.status    = status_reg;
        res_word.cur_row   = ROW_IO_W'(row_reg);
        res_word.cur_col   = COL_IO_W'(col_reg);
        res_word.rows_used = TOTAL_O_W'(total_reg);
        res_word.read_byte = rbyte_reg;
    end

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        total_next    = total_reg;
        scan_row_next = scan_row_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        aux_next      = aux_reg;
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        rbyte_next    = rbyte_reg;
        mv_start      = 1'b0;
        mv_src        = '0;
        mv_dst        = '0;
        mv_cnt        = '0;
        mv_op         = '0;
        mem_we        = 1'b0;
        mem_waddr     = {row_reg, col_reg};
        mem_wdata     = cmd_reg.char_code;
        mem_re        = 1'b0;
        mem_raddr     = {row_reg, col_reg};

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next    = in_word;
                    status_next = 1'b0;
                    rbyte_next  = '0;
                    phase_next  = 1'b0;
                    state_next  = ST_DISP;
                end
            end

            ST_DISP: begin
                state_next = ST_FIN;
                case (cmd_reg.kind)
                    K_INSERT: begin
                        if (cmd_reg.char_code == CH_NUL) begin
                            status_next = 1'b1;
                        end else if (cmd_reg.char_code == CH_NL) begin
                            if (total_reg >= (RW+1)'(LINES)) begin
                                status_next = 1'b1;
                            end else begin
                                // push the rows below the cursor down by one
                                mv_start   = 1'b1;
                                mv_op.desc = 1'b1;
                                mv_src     = {last_row, COL_TOP};
                                mv_dst     = {RW'(total_reg), COL_TOP};
                                mv_cnt     = CNT_W'(rows_below) << CW;
                                ret_next   = ST_SPL1;
                                state_next = ST_MWAIT;
                            end
                        end else begin
                            scan_row_next = row_reg;
                            idx_next      = '0;
                            ret_next      = ST_INS1;
                            state_next    = ST_LEN_RD;
                        end
                    end
                    K_DELETE: begin
                        if (col_reg != '0) begin
                            // close the gap; the top byte of the row is always zero
                            mv_start   = 1'b1;
                            mv_src     = {row_reg, col_reg};
                            mv_dst     = {row_reg, col_reg - CW'(1)};
                            mv_cnt     = ROW_SPAN - CNT_W'(col_reg);
                            ret_next   = ST_DEL_A;
                            state_next = ST_MWAIT;
                        end else if (row_reg != '0) begin
                            scan_row_next = row_reg;
                            idx_next      = '0;
                            ret_next      = ST_DEL1;
                            state_next    = ST_LEN_RD;
                        end
                    end
                    K_DEL_WORD: begin
                        if (col_reg != '0) begin
                            aux_next   = col_reg;
                            ret_next   = ST_DW1;
                            state_next = ST_WL_RD;
                        end
                    end
                    K_LEFT: begin
                        if (col_reg != '0) begin
                            col_next = col_reg - CW'(1);
                        end else if (row_reg != '0) begin
                            row_next      = row_up;
                            scan_row_next = row_up;
                            idx_next      = '0;
                            ret_next      = ST_LFT1;
                            state_next    = ST_LEN_RD;
                        end
                    end
                    K_RIGHT: begin
                        mem_re     = 1'b1;
                        state_next = ST_RT_EV;
                    end
                    K_UP: begin
                        if (row_reg != '0) begin
                            row_next      = row_up;
                            scan_row_next = row_up;
                            idx_next      = '0;
                            ret_next      = ST_CLAMP;
                            state_next    = ST_LEN_RD;
                        end
                    end
                    K_DOWN: begin
                        if ((RW+1)'(row_reg) + (RW+1)'(1) < total_reg) begin
                            row_next      = row_dn;
                            scan_row_next = row_dn;
                            idx_next      = '0;
                            ret_next      = ST_CLAMP;
                            state_next    = ST_LEN_RD;
                        end
                    end
                    K_WORD_LEFT: begin
                        ret_next   = ST_FIN;
                        state_next = ST_WL_RD;
                    end
                    K_WORD_RIGHT: begin
                        state_next = ST_WR_RD;
                    end
                    K_READ: begin
                        if ((cmd_reg.read_row < LINES) && (cmd_reg.read_col < COLS)) begin
                            mem_re     = 1'b1;
                            mem_raddr  = {RW'(cmd_reg.read_row), CW'(cmd_reg.read_col)};
                            state_next = ST_RD_EV;
                        end
                    end
                    K_CLEAR: begin
                        ret_next   = ST_FIN;
                        state_next = ST_CLR;
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_CLR: begin
                mv_start   = 1'b1;
                mv_op.fill = 1'b1;
                mv_cnt     = CNT_W'(LINES) << CW;
                row_next   = '0;
                col_next   = '0;
                total_next = (RW+1)'(1);
                state_next = ST_MWAIT;
            end

            ST_MWAIT: begin
                if (!mv_busy) begin
                    state_next = ret_reg;
                end
            end

            // line length: walk to the terminator
            ST_LEN_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = {scan_row_reg, idx_reg};
                state_next = ST_LEN_EV;
            end
            ST_LEN_EV: begin
                if ((mem_rdata == CH_NUL) || (idx_reg == COL_LAST)) begin
                    len_next   = idx_reg;
                    state_next = ret_reg;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_LEN_RD;
                end
            end

            // word left: skip spaces, then the word
            ST_WL_RD: begin
                if (col_reg == '0) begin
                    state_next = ret_reg;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = {row_reg, col_reg - CW'(1)};
                    state_next = ST_WL_EV;
                end
            end
            ST_WL_EV: begin
                state_next = ST_WL_RD;
                if (!phase_reg) begin
                    if (is_space) begin
                        col_next = col_reg - CW'(1);
                    end else begin
                        phase_next = 1'b1;
                    end
                end else if (!is_space) begin
                    col_next = col_reg - CW'(1);
                end else begin
                    state_next = ret_reg;
                end
            end

            // word right: skip the word, then spaces; stop at the terminator
            ST_WR_RD: begin
                mem_re     = 1'b1;
                state_next = ST_WR_EV;
            end
            ST_WR_EV: begin
                state_next = ST_WR_RD;
                if (!phase_reg) begin
                    if ((mem_rdata != CH_NUL) && !is_space) begin
                        col_next = col_reg + CW'(1);
                    end else begin
                        phase_next = 1'b1;
                    end
                end else if (is_space) begin
                    col_next = col_reg + CW'(1);
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_RT_EV: begin
                state_next = ST_FIN;
                if (mem_rdata != CH_NUL) begin
                    col_next = col_reg + CW'(1);
                end else if ((RW+1)'(row_reg) + (RW+1)'(1) < total_reg) begin
                    row_next = row_dn;
                    col_next = '0;
                end
            end

            ST_RD_EV: begin
                rbyte_next = mem_rdata;
                state_next = ST_FIN;
            end

            ST_INS1: begin
                if (len_reg >= COL_LAST) begin
                    status_next = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    // open a gap at the cursor
                    mv_start   = 1'b1;
                    mv_op.desc = 1'b1;
                    mv_src     = {row_reg, len_reg - CW'(1)};
                    mv_dst     = {row_reg, len_reg};
                    mv_cnt     = CNT_W'(len_reg) - CNT_W'(col_reg);
                    ret_next   = ST_INS2;
                    state_next = ST_MWAIT;
                end
            end
            ST_INS2: begin
                mem_we     = 1'b1;
                col_next   = col_reg + CW'(1);
                state_next = ST_FIN;
            end

            ST_SPL1: begin
                // tail of the line to the start of the new row
                mv_start   = 1'b1;
                mv_src     = {row_reg, col_reg};
                mv_dst     = {row_dn, CW'(0)};
                mv_cnt     = ROW_SPAN - CNT_W'(col_reg);
                ret_next   = ST_SPL2;
                state_next = ST_MWAIT;
            end
            ST_SPL2: begin
                mv_start   = 1'b1;
                mv_op.fill = 1'b1;
                mv_dst     = {row_dn, CW'(0) - col_reg};
                mv_cnt     = CNT_W'(col_reg);
                ret_next   = ST_SPL3;
                state_next = ST_MWAIT;
            end
            ST_SPL3: begin
                mv_start   = 1'b1;
                mv_op.fill = 1'b1;
                mv_dst     = {row_reg, col_reg};
                mv_cnt     = ROW_SPAN - CNT_W'(col_reg);
                ret_next   = ST_SPL4;
                state_next = ST_MWAIT;
            end
            ST_SPL4: begin
                row_next   = row_dn;
                col_next   = '0;
                total_next = total_reg + (RW+1)'(1);
                state_next = ST_FIN;
            end

            ST_DEL_A: begin
                col_next   = col_reg - CW'(1);
                state_next = ST_FIN;
            end
            ST_DEL1: begin
                aux_next      = len_reg;
                scan_row_next = row_up;
                idx_next      = '0;
                ret_next      = ST_DEL2;
                state_next    = ST_LEN_RD;
            end
            ST_DEL2: begin
                if ((CW+1)'(len_reg) + (CW+1)'(aux_reg) >= (CW+1)'(COLS)) begin
                    status_next = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    // append this line to the one above
                    mv_start   = 1'b1;
                    mv_src     = {row_reg, CW'(0)};
                    mv_dst     = {row_up, len_reg};
                    mv_cnt     = ROW_SPAN - CNT_W'(len_reg);
                    ret_next   = ST_DEL3;
                    state_next = ST_MWAIT;
                end
            end
            ST_DEL3: begin
                mv_start   = 1'b1;
                mv_src     = {row_dn, CW'(0)};
                mv_dst     = {row_reg, CW'(0)};
                mv_cnt     = CNT_W'(rows_below) << CW;
                ret_next   = ST_DEL4;
                state_next = ST_MWAIT;
            end
            ST_DEL4: begin
                mv_start   = 1'b1;
                mv_op.fill = 1'b1;
                mv_dst     = {last_row, CW'(0)};
                mv_cnt     = ROW_SPAN;
                ret_next   = ST_DEL5;
                state_next = ST_MWAIT;
            end
            ST_DEL5: begin
                total_next = total_reg - (RW+1)'(1);
                row_next   = row_up;
                col_next   = len_reg;
                state_next = ST_FIN;
            end

            ST_DW1: begin
                mv_start   = 1'b1;
                mv_src     = {row_reg, aux_reg};
                mv_dst     = {row_reg, col_reg};
                mv_cnt     = ROW_SPAN - CNT_W'(aux_reg);
                ret_next   = ST_DW2;
                state_next = ST_MWAIT;
            end
            ST_DW2: begin
                mv_start   = 1'b1;
                mv_op.fill = 1'b1;
                mv_dst     = {row_reg, col_reg - aux_reg};
                mv_cnt     = CNT_W'(aux_reg) - CNT_W'(col_reg);
                ret_next   = ST_FIN;
                state_next = ST_MWAIT;
            end

            ST_LFT1: begin
                col_next   = len_reg;
                state_next = ST_FIN;
            end
            ST_CLAMP: begin
                if (col_reg > len_reg) begin
                    col_next = len_reg;
                end
                state_next = ST_FIN;
            end

            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            ret_reg   <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            total_reg <= (RW+1)'(1);
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            total_reg <= total_next;
            phase_reg <= phase_next;
        end
        scan_row_reg <= scan_row_next;
        idx_reg      <= idx_next;
        len_reg      <= len_next;
        aux_reg      <= aux_next;
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        rbyte_reg    <= rbyte_next;
    end

endmodule

FILE: design/text_line_buffer_editor_core.sv
`timescale 1ns / 1ps
// Line-buffer text editor. The text lives in one byte-wide synchronous RAM of
// LINES rows, each row padded to a power of two of at least COLS bytes, with the
// cursor and row count in registers. Each command word on s_ gives exactly one
// result word on m_. Commands run one at a time through a sequencer; the RAM
// port sets the cost. Moves and deletes within a line that need the line length
// walk the row one byte at a time, a read and then a test per byte. Shifting text
// runs a block mover at one byte per cycle: insert and delete within a row shift
// up to one row span of bytes, and a split or merge shifts every row below the
// cursor. Clear and the clearing pass after reset zero the whole RAM, during
// which s_ready stays low. A finished result waits in an output register, so
// the next command is taken while m_valid is still pending.
module text_line_buffer_editor_core #(
    parameter int LINES = tlbe_pkg::DEF_LINES,
    parameter int COLS  = tlbe_pkg::DEF_COLS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlbe_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tlbe_pkg::out_word_t m_data
);
    import tlbe_pkg::*;

    localparam int RW = $clog2(LINES);
    localparam int CW = $clog2(COLS);
    localparam int AW = RW + CW;

    // sequencer to output register
    logic      res_ready;
    logic      res_valid;
    out_word_t res_word;

    // block mover request and status
    logic          mv_start;
    logic [AW-1:0] mv_src;
    logic [AW-1:0] mv_dst;
    logic [AW:0]   mv_cnt;
    mv_op_t        mv_op;
    logic          mv_busy;

    // RAM port from each side
    logic              c_we, c_re, v_we, v_re;
    logic [AW-1:0]     c_waddr, c_raddr, v_waddr, v_raddr;
    logic [BYTE_W-1:0] c_wdata, v_wdata;

    // RAM port after the mux
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    // result word register
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    tlbe_ctrl #(
        .LINES (LINES),
        .COLS  (COLS),
        .RW    (RW),
        .CW    (CW),
        .AW    (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_data),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_word  (res_word),
        .mv_start  (mv_start),
        .mv_src    (mv_src),
        .mv_dst    (mv_dst),
        .mv_cnt    (mv_cnt),
        .mv_op     (mv_op),
        .mv_busy   (mv_busy),
        .mem_we    (c_we),
        .mem_waddr (c_waddr),
        .mem_wdata (c_wdata),
        .mem_re    (c_re),
        .mem_raddr (c_raddr),
        .mem_rdata (ram_rdata)
    );

    tlbe_mover #(
        .AW (AW)
    ) u_mover (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mv_start),
        .src       (mv_src),
        .dst       (mv_dst),
        .cnt       (mv_cnt),
        .op        (mv_op),
        .busy      (mv_busy),
        .mem_we    (v_we),
        .mem_waddr (v_waddr),
        .mem_wdata (v_wdata),
        .mem_re    (v_re),
        .mem_raddr (v_raddr),
        .mem_rdata (ram_rdata)
    );

    // hand the RAM to the mover while it runs
    always_comb begin
        if (mv_busy) begin
            ram_we    = v_we;
            ram_waddr = v_waddr;
            ram_wdata = v_wdata;
            ram_re    = v_re;
            ram_raddr = v_raddr;
        end else begin
            ram_we    = c_we;
            ram_waddr = c_waddr;
            ram_wdata = c_wdata;
            ram_re    = c_re;
            ram_raddr = c_raddr;
        end
    end

    tlbe_mem #(
        .AW (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // hold the result word until taken; load a new one when the slot frees
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res_word;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
